/* src/rfo_pkg.sv */
// Shared types, codes and constants for the rectangle fill and outline rasterizer.
package rfo_pkg;

    localparam int DEF_MAX_SIDE  = 256;
    localparam int DEF_FRAC_BITS = 8;

    localparam int COORD_W = 20;
    localparam int CHAR_W  = 8;
    localparam int SIZE_W  = 9;
    localparam int CFG_W   = 9;
    localparam int IDX_IN_W = 8;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_CLEAR = 2'd0;
    localparam kind_t KIND_DRAW  = 2'd1;
    localparam kind_t KIND_READ  = 2'd2;

    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_CANVAS_WIDTH  = 2'd0;
    localparam reg_index_t REG_CANVAS_HEIGHT = 2'd1;
    localparam reg_index_t REG_BACKGROUND    = 2'd2;

    localparam logic [SIZE_W-1:0] RST_CANVAS_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0] RST_CANVAS_HEIGHT = 9'd256;
    localparam logic [CHAR_W-1:0] RST_BACKGROUND    = 8'd32;

    // Classification of the current cell against the loaded rectangle.
    typedef struct packed {
        logic in_rect;
        logic on_edge;
    } hit_t;

endpackage

/* src/rfo_ram.sv */
// Generic single-port RAM with registered read data.
module rfo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* src/rfo_hit.sv */
// Edge unit: holds the rectangle's integer pixel bounds and classifies one cell per cycle.
module rfo_hit #(
    parameter int FRAC_BITS = rfo_pkg::DEF_FRAC_BITS,
    parameter int IDX_W     = 8
) (
    input  logic                              clk,
    input  logic                              load,
    input  logic signed [rfo_pkg::COORD_W-1:0] rect_x,
    input  logic signed [rfo_pkg::COORD_W-1:0] rect_y,
    input  logic signed [rfo_pkg::COORD_W-1:0] rect_w,
    input  logic signed [rfo_pkg::COORD_W-1:0] rect_h,
    input  logic [IDX_W-1:0]                  col,
    input  logic [IDX_W-1:0]                  row,
    output rfo_pkg::hit_t                     hit
);
    import rfo_pkg::*;

    localparam int BND_W = COORD_W + 2;
    localparam logic signed [BND_W-1:0] ONE_M1 = BND_W'((1 << FRAC_BITS) - 1);

    // Pixel c lies inside when ceil(x) <= c <= floor(x + w) in pixel units;
    // it is within one unit of an edge exactly when it equals one of the bounds.
    logic signed [BND_W-1:0] xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic signed [BND_W-1:0] x_ext, y_ext, xe_ext, ye_ext;
    logic signed [BND_W-1:0] cpos, rpos;
    logic                    in_x, in_y, edge_x, edge_y;

    assign x_ext  = BND_W'(rect_x);
    assign y_ext  = BND_W'(rect_y);
    assign xe_ext = BND_W'(rect_x) + BND_W'(rect_w);
    assign ye_ext = BND_W'(rect_y) + BND_W'(rect_h);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            xlo_reg <= (x_ext + ONE_M1) >>> FRAC_BITS;
            ylo_reg <= (y_ext + ONE_M1) >>> FRAC_BITS;
            xhi_reg <= xe_ext >>> FRAC_BITS;
            yhi_reg <= ye_ext >>> FRAC_BITS;
        end
    end

    assign cpos   = signed'(BND_W'(col));
    assign rpos   = signed'(BND_W'(row));
    assign in_x   = (cpos >= xlo_reg) && (cpos <= xhi_reg);
    assign in_y   = (rpos >= ylo_reg) && (rpos <= yhi_reg);
    assign edge_x = (cpos == xlo_reg) || (cpos == xhi_reg);
    assign edge_y = (rpos == ylo_reg) || (rpos == yhi_reg);

    assign hit.in_rect = in_x && in_y;
    assign hit.on_edge = in_x && in_y && (edge_x || edge_y);

endmodule

/* src/rfo_ctrl.sv */
// Sequencer: accepts requests, scans the canvas cell by cell, and holds the result.
module rfo_ctrl #(
    parameter int IDX_W    = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        kind,
    input  logic signed [rfo_pkg::COORD_W-1:0] rect_w,
    input  logic signed [rfo_pkg::COORD_W-1:0] rect_h,
    input  logic                              fill_mode,
    input  logic [rfo_pkg::CHAR_W-1:0]        paint,
    input  logic [rfo_pkg::IDX_IN_W-1:0]      read_col,
    input  logic [rfo_pkg::IDX_IN_W-1:0]      read_row,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rfo_pkg::CHAR_W-1:0]        cell_value,
    output logic                              status,
    input  logic [rfo_pkg::SIZE_W-1:0]        cols,
    input  logic [rfo_pkg::SIZE_W-1:0]        rows,
    input  logic [rfo_pkg::CHAR_W-1:0]        background,
    input  rfo_pkg::hit_t                     hit,
    output logic                              hit_load,
    output logic [IDX_W-1:0]                  col,
    output logic [IDX_W-1:0]                  row,
    output logic                              mem_we,
    output logic [rfo_pkg::CHAR_W-1:0]        mem_wdata,
    input  logic [rfo_pkg::CHAR_W-1:0]        mem_rdata
);
    import rfo_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_RADDR = 5'b00100,
        S_RDATA = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    localparam int CMP_W = 11;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    col_reg, col_next, row_reg, row_next;
    logic                clear_reg, clear_next, fill_reg, fill_next;
    logic [CHAR_W-1:0]   wdata_reg, wdata_next;
    logic [SIZE_W-1:0]   cols_reg, cols_next, rows_reg, rows_next;
    logic [CHAR_W-1:0]   value_reg, value_next;
    logic                status_reg, status_next;
    logic                accept, empty, last_col, last_row, rd_in_range;

    assign accept      = in_valid && (state_reg == S_IDLE);
    assign empty       = (cols == '0) || (rows == '0);
    assign rd_in_range = (SIZE_W'(read_col) < cols) && (SIZE_W'(read_row) < rows);
    assign last_col    = (CMP_W'(col_reg) + CMP_W'(1)) == CMP_W'(cols_reg);
    assign last_row    = (CMP_W'(row_reg) + CMP_W'(1)) == CMP_W'(rows_reg);

    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        clear_next  = clear_reg;
        fill_next   = fill_reg;
        wdata_next  = wdata_reg;
        cols_next   = cols_reg;
        rows_next   = rows_reg;
        value_next  = value_reg;
        status_next = status_reg;
        hit_load    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next  = '0;
                    status_next = 1'b0;
                    col_next    = '0;
                    row_next    = '0;
                    cols_next   = cols;
                    rows_next   = rows;
                    fill_next   = fill_mode;
                    state_next  = S_DONE;
                    case (kind)
                        KIND_CLEAR:
                        begin
                            clear_next = 1'b1;
                            wdata_next = background;
                            if (!empty)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        KIND_DRAW:
                        begin
                            clear_next = 1'b0;
                            wdata_next = paint;
                            hit_load   = 1'b1;
                            if ((rect_w <= 0) || (rect_h <= 0))
                            begin
                                status_next = 1'b1;
                            end
                            else if (!empty)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        KIND_READ:
                        begin
                            col_next = IDX_W'(read_col);
                            row_next = IDX_W'(read_row);
                            if (rd_in_range)
                            begin
                                state_next = S_RADDR;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (last_col)
                begin
                    col_next = '0;
                    if (last_row)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        row_next = row_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + IDX_W'(1);
                end
            end
            S_RADDR:
            begin
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                value_next = mem_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg    <= col_next;
        row_reg    <= row_next;
        clear_reg  <= clear_next;
        fill_reg   <= fill_next;
        wdata_reg  <= wdata_next;
        cols_reg   <= cols_next;
        rows_reg   <= rows_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_DONE);
    assign cell_value = value_reg;
    assign status     = status_reg;
    assign col        = col_reg;
    assign row        = row_reg;
    assign mem_wdata  = wdata_reg;
    assign mem_we     = (state_reg == S_SCAN) &&
                        (clear_reg || hit.on_edge || (hit.in_rect && fill_reg));

    a_write_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_SCAN))
        else $error("canvas written outside a scan");

    a_scan_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |->
            ((CMP_W'(col_reg) < CMP_W'(cols_reg)) && (CMP_W'(row_reg) < CMP_W'(rows_reg))))
        else $error("scan position outside the canvas in use");

    a_rdata_follows_raddr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDATA) |-> $past(state_reg == S_RADDR))
        else $error("read data captured without an address cycle");

    a_reject_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_reg) |-> (value_reg == '0))
        else $error("rejected draw carries a cell value");

endmodule

/* src/rectangle_fill_outline_rasterizer_top.sv */
// Top level of the rectangle fill and outline rasterizer on a character canvas.
// The block holds a MAX_SIDE by MAX_SIDE canvas of 8-bit characters in one
// single-port RAM and handles one request at a time; in_stall stays high from
// the accepting edge until the result has been taken. A clear request writes
// the background value into every cell in use and a draw request tests every
// cell in use against the rectangle, both scanning row by row at one cell per
// cycle before presenting the result. The scan rate is set by the single write
// port of the canvas RAM. A read goes through an address state, a state that
// captures the registered RAM data, and the result. A rejected draw, a request
// on an empty canvas, a read outside the canvas in use and the unused kind
// code go straight from acceptance to the result. Rectangle coordinates are
// signed fixed point with FRAC_BITS fraction bits; at the start of a draw the
// edge unit turns them into integer pixel bounds, after which each cell needs
// only compares. The canvas powers up with undefined contents and has no
// clearing pass, so a cell should be read only after a clear has written it.
// Configuration writes take effect at once and must be made while idle.
module rectangle_fill_outline_rasterizer_top #(
    parameter int MAX_SIDE  = rfo_pkg::DEF_MAX_SIDE,
    parameter int FRAC_BITS = rfo_pkg::DEF_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         kind,
    input  logic signed [rfo_pkg::COORD_W-1:0] rect_x,
    input  logic signed [rfo_pkg::COORD_W-1:0] rect_y,
    input  logic signed [rfo_pkg::COORD_W-1:0] rect_w,
    input  logic signed [rfo_pkg::COORD_W-1:0] rect_h,
    input  logic                               fill_mode,
    input  logic [rfo_pkg::CHAR_W-1:0]         paint,
    input  logic [rfo_pkg::IDX_IN_W-1:0]       read_col,
    input  logic [rfo_pkg::IDX_IN_W-1:0]       read_row,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rfo_pkg::CHAR_W-1:0]         cell_value,
    output logic                               status,
    input  logic                               cfg_wr_en,
    input  logic [1:0]                         cfg_index,
    input  logic [rfo_pkg::CFG_W-1:0]          cfg_wr_data
);
    import rfo_pkg::*;

    // Cell index width; the canvas address is the row index over the column index.
    localparam int IDX_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int CMP_W   = 11;

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [CHAR_W-1:0] background_reg;
    logic [SIZE_W-1:0] cols, rows;

    hit_t              hit;
    logic              hit_load;
    logic [IDX_W-1:0]  col, row;
    logic              mem_we;
    logic [CHAR_W-1:0] mem_wdata, mem_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= RST_CANVAS_WIDTH;
            height_reg     <= RST_CANVAS_HEIGHT;
            background_reg <= RST_BACKGROUND;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CANVAS_WIDTH:  width_reg      <= cfg_wr_data;
                REG_CANVAS_HEIGHT: height_reg     <= cfg_wr_data;
                REG_BACKGROUND:    background_reg <= cfg_wr_data[CHAR_W-1:0];
                default:           ;
            endcase
        end
    end

    // Sizes above the physical canvas act as the full canvas.
    assign cols = (CMP_W'(width_reg) > CMP_W'(MAX_SIDE))  ? SIZE_W'(MAX_SIDE) : width_reg;
    assign rows = (CMP_W'(height_reg) > CMP_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : height_reg;

    rfo_ctrl #(
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .rect_w     (rect_w),
        .rect_h     (rect_h),
        .fill_mode  (fill_mode),
        .paint      (paint),
        .read_col   (read_col),
        .read_row   (read_row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_value (cell_value),
        .status     (status),
        .cols       (cols),
        .rows       (rows),
        .background (background_reg),
        .hit        (hit),
        .hit_load   (hit_load),
        .col        (col),
        .row        (row),
        .mem_we     (mem_we),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata)
    );

    rfo_hit #(
        .FRAC_BITS (FRAC_BITS),
        .IDX_W     (IDX_W)
    ) u_hit (
        .clk    (clk),
        .load   (hit_load),
        .rect_x (rect_x),
        .rect_y (rect_y),
        .rect_w (rect_w),
        .rect_h (rect_h),
        .col    (col),
        .row    (row),
        .hit    (hit)
    );

    rfo_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_canvas (
        .clk   (clk),
        .we    (mem_we),
        .addr  ({row, col}),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

/* test/tb_rectangle_fill_outline_rasterizer_top.sv */
// Self-checking testbench for the rectangle fill and outline rasterizer top level.
module tb_rectangle_fill_outline_rasterizer_top;

    import rfo_pkg::*;

    // The testbench keeps its own copy of the canvas and the three registers.
    // Every accepted request is applied to that copy at the accepting edge,
    // and the result it should produce is queued. Each result taken from the
    // block is compared with the oldest queued one.
    localparam int SIDE = DEF_MAX_SIDE;
    localparam int FRAC = DEF_FRAC_BITS;
    localparam int UNIT = 1 << FRAC;

    // Kind code three is a no-operation request; the package does not name it.
    localparam kind_t KIND_IDLE = 2'd3;
    // Register index three is not used by the block; writes to it do nothing.
    localparam reg_index_t REG_UNUSED = 2'd3;

    localparam int COORD_MIN = -(1 << (COORD_W - 1));
    localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;

    typedef struct {
        kind_t                      kind;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  w;
        logic signed [COORD_W-1:0]  h;
        logic                       fill;
        logic [CHAR_W-1:0]          paint;
        logic [IDX_IN_W-1:0]        col;
        logic [IDX_IN_W-1:0]        row;
    } request_t;

    typedef struct {
        logic [CHAR_W-1:0] cell_value;
        logic              status;
    } raster_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    kind_t                      kind;
    logic signed [COORD_W-1:0]  rect_x;
    logic signed [COORD_W-1:0]  rect_y;
    logic signed [COORD_W-1:0]  rect_w;
    logic signed [COORD_W-1:0]  rect_h;
    logic                       fill_mode;
    logic [CHAR_W-1:0]          paint;
    logic [IDX_IN_W-1:0]        read_col;
    logic [IDX_IN_W-1:0]        read_row;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [CHAR_W-1:0]          cell_value;
    logic                       status;
    logic                       cfg_wr_en;
    reg_index_t                 cfg_index;
    logic [CFG_W-1:0]           cfg_wr_data;

    // Shadow canvas and register copies used for prediction.
    logic [CHAR_W-1:0] canvas_model [0:SIDE*SIDE-1];
    logic [SIZE_W-1:0] model_cols;
    logic [SIZE_W-1:0] model_rows;
    logic [CHAR_W-1:0] model_background;

    raster_result_t pending_results[$];

    // When idling is cleared, neither side inserts gaps or stalls.
    bit idling = 1'b1;
    int stall_left = 0;
    int n_errors = 0;
    int n_requests = 0;
    int n_draws = 0;
    int n_rejected = 0;
    int n_reads = 0;
    int n_settings = 0;

    always #2 clk = ~clk;

    rectangle_fill_outline_rasterizer_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_w      (rect_w),
        .rect_h      (rect_h),
        .fill_mode   (fill_mode),
        .paint       (paint),
        .read_col    (read_col),
        .read_row    (read_row),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cell_value  (cell_value),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // Applies one request to the shadow canvas and returns the result the
    // block should give for it. A pixel is hit when it lies in the closed
    // rectangle; an outline keeps only pixels less than one unit from an edge.
    function automatic raster_result_t apply_request(request_t r);
        raster_result_t res;
        int cols;
        int rows;
        longint rx;
        longint ry;
        longint rw;
        longint rh;
        longint px;
        longint py;
        longint one;
        bit in_rect;
        bit near_edge;
        res.cell_value = '0;
        res.status = 1'b0;
        cols = (model_cols > SIDE) ? SIDE : int'(model_cols);
        rows = (model_rows > SIDE) ? SIDE : int'(model_rows);
        one = longint'(UNIT);
        case (r.kind)
            KIND_CLEAR:
                for (int rr = 0; rr < rows; rr++)
                    for (int cc = 0; cc < cols; cc++)
                        canvas_model[rr*SIDE + cc] = model_background;
            KIND_DRAW:
            begin
                rx = longint'(r.x);
                ry = longint'(r.y);
                rw = longint'(r.w);
                rh = longint'(r.h);
                if (rw <= 0 || rh <= 0) begin
                    res.status = 1'b1;
                end else begin
                    for (int rr = 0; rr < rows; rr++) begin
                        for (int cc = 0; cc < cols; cc++) begin
                            px = longint'(cc) * one;
                            py = longint'(rr) * one;
                            in_rect = px >= rx && px <= rx + rw && py >= ry && py <= ry + rh;
                            near_edge = px - rx < one || rx + rw - px < one ||
                                        py - ry < one || ry + rh - py < one;
                            if (in_rect && (r.fill || near_edge))
                                canvas_model[rr*SIDE + cc] = r.paint;
                        end
                    end
                end
            end
            KIND_READ:
                if (int'(r.col) < cols && int'(r.row) < rows)
                    res.cell_value = canvas_model[int'(r.row)*SIDE + int'(r.col)];
            default:
                ;
        endcase
        return res;
    endfunction

    // A request with every field random; the helpers below override fields.
    function automatic request_t noise_request();
        request_t r;
        r.kind = kind_t'($urandom_range(0, 3));
        r.x = COORD_W'($urandom);
        r.y = COORD_W'($urandom);
        r.w = COORD_W'($urandom);
        r.h = COORD_W'($urandom);
        r.fill = 1'($urandom_range(0, 1));
        r.paint = CHAR_W'($urandom);
        r.col = IDX_IN_W'($urandom);
        r.row = IDX_IN_W'($urandom);
        return r;
    endfunction

    function automatic request_t make_plain(kind_t k);
        request_t r;
        r = noise_request();
        r.kind = k;
        return r;
    endfunction

    function automatic request_t make_draw(int x, int y, int w, int h, bit fill,
                                           logic [CHAR_W-1:0] value);
        request_t r;
        r = noise_request();
        r.kind = KIND_DRAW;
        r.x = x[COORD_W-1:0];
        r.y = y[COORD_W-1:0];
        r.w = w[COORD_W-1:0];
        r.h = h[COORD_W-1:0];
        r.fill = fill;
        r.paint = value;
        return r;
    endfunction

    function automatic request_t make_read(int col, int row);
        request_t r;
        r = noise_request();
        r.kind = KIND_READ;
        r.col = col[IDX_IN_W-1:0];
        r.row = row[IDX_IN_W-1:0];
        return r;
    endfunction

    // Random request for a canvas of the given size. Draws are placed around
    // the canvas so that edges, interiors and misses all occur; a third of
    // them sit on whole pixel positions so edges land exactly on pixels.
    function automatic request_t random_request(int cols, int rows);
        request_t r;
        int pick;
        int x;
        int y;
        int w;
        int h;
        int col_top;
        int row_top;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            x = int'($urandom_range(0, (cols + 6) * UNIT)) - 3 * UNIT;
            y = int'($urandom_range(0, (rows + 6) * UNIT)) - 3 * UNIT;
            if ($urandom_range(0, 3) == 0) begin
                w = $urandom_range(1, 2 * UNIT);
                h = $urandom_range(1, 2 * UNIT);
            end else begin
                w = $urandom_range(1, (cols + 4) * UNIT);
                h = $urandom_range(1, (rows + 4) * UNIT);
            end
            if ($urandom_range(0, 2) == 0) begin
                x = x & ~(UNIT - 1);
                y = y & ~(UNIT - 1);
                w = (w & ~(UNIT - 1)) + UNIT;
                h = (h & ~(UNIT - 1)) + UNIT;
            end
            if ($urandom_range(0, 6) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    w = -int'($urandom_range(0, 4 * UNIT));
                else
                    h = -int'($urandom_range(0, 4 * UNIT));
            end
            r = make_draw(x, y, w, h, 1'($urandom_range(0, 1)), CHAR_W'($urandom));
        end else if (pick < 80) begin
            col_top = (cols + 1 > 255) ? 255 : cols + 1;
            row_top = (rows + 1 > 255) ? 255 : rows + 1;
            if ($urandom_range(0, 3) == 0)
                r = make_read($urandom_range(0, 255), $urandom_range(0, 255));
            else
                r = make_read($urandom_range(0, col_top), $urandom_range(0, row_top));
        end else if (pick < 87) begin
            r = make_plain(KIND_CLEAR);
        end else if (pick < 92) begin
            r = make_plain(KIND_IDLE);
        end else begin
            r = noise_request();
        end
        return r;
    endfunction

    // Presents one request and waits until it is accepted. Valid is left
    // high so that a following request can be presented at the same edge
    // without lowering it in between.
    task automatic send_request(request_t r);
        raster_result_t res;
        if (idling && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= r.kind;
        rect_x    <= r.x;
        rect_y    <= r.y;
        rect_w    <= r.w;
        rect_h    <= r.h;
        fill_mode <= r.fill;
        paint     <= r.paint;
        read_col  <= r.col;
        read_row  <= r.row;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = apply_request(r);
        pending_results.push_back(res);
        n_requests++;
        if (r.kind == KIND_DRAW)
            n_draws++;
        if (r.kind == KIND_READ)
            n_reads++;
        if (res.status)
            n_rejected++;
    endtask

    // Drops valid and waits until every queued result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(reg_index_t idx, int data);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data[CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CANVAS_WIDTH:  model_cols = data[SIZE_W-1:0];
            REG_CANVAS_HEIGHT: model_rows = data[SIZE_W-1:0];
            REG_BACKGROUND:    model_background = data[CHAR_W-1:0];
            default:           ;
        endcase
    endtask

    // Registers are only written once the block has gone idle.
    task automatic set_canvas(int cols, int rows, int bg);
        settle();
        write_register(REG_CANVAS_WIDTH, cols);
        write_register(REG_CANVAS_HEIGHT, rows);
        write_register(REG_BACKGROUND, bg);
        n_settings++;
    endtask

    // Reset register values: a full 256 by 256 clear with the reset background.
    task automatic test_reset_defaults();
        send_request(make_plain(KIND_IDLE));
        send_request(make_plain(KIND_CLEAR));
        send_request(make_read(0, 0));
        send_request(make_read(255, 255));
    endtask

    // Draws with a zero or negative width or height are refused and leave
    // the canvas alone.
    task automatic test_rejected_draws();
        send_request(make_draw(0, 0, 0, UNIT, 1'b1, 8'hAA));
        send_request(make_draw(0, 0, COORD_MIN, UNIT, 1'b0, 8'h55));
        send_request(make_draw(UNIT, UNIT, 4 * UNIT, 0, 1'b1, 8'hAA));
        send_request(make_draw(UNIT, UNIT, COORD_MAX, -1, 1'b1, 8'h55));
    endtask

    // One filled draw across almost the whole full-size canvas.
    task automatic test_full_canvas_draw();
        send_request(make_draw(10 * UNIT + UNIT / 2, 3 * UNIT, 200 * UNIT + 77, 240 * UNIT,
                               1'b1, 8'hFF));
        send_request(make_read(10, 3));
        send_request(make_read(210, 243));
    endtask

    // Outlines and fills with fractional edges, and rectangles at the
    // extremes of the coordinate range, on a small canvas.
    task automatic test_outline_and_extremes();
        set_canvas(16, 12, 0);
        send_request(make_plain(KIND_CLEAR));
        send_request(make_draw(2 * UNIT + UNIT / 2, UNIT, 9 * UNIT + UNIT / 4, 6 * UNIT,
                               1'b0, "R"));
        send_request(make_draw(-(3 * UNIT / 4), 7 * UNIT + UNIT / 2, 4 * UNIT, 3 * UNIT,
                               1'b1, "r"));
        // Covers the whole canvas but every edge is far away: nothing painted.
        send_request(make_draw(-2 * UNIT, -2 * UNIT, COORD_MAX, COORD_MAX, 1'b0, 8'h2A));
        send_request(make_draw(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1, 8'h01));
        send_request(make_draw(COORD_MAX, COORD_MAX, 1, 1, 1'b1, 8'h02));
        send_request(make_read(3, 1));
        send_request(make_read(255, 11));
    endtask

    // Shrinking the canvas keeps cell addresses; cells past the new edge read 0.
    task automatic test_resize_keeps_cells();
        set_canvas(7, 5, 0);
        send_request(make_read(3, 1));
        send_request(make_read(10, 3));
    endtask

    // A zero width or height register leaves no cells in use.
    task automatic test_zero_size();
        set_canvas(0, 5, 9);
        send_request(make_plain(KIND_CLEAR));
        send_request(make_draw(0, 0, 4 * UNIT, 4 * UNIT, 1'b1, 8'h77));
        send_request(make_read(0, 0));
        set_canvas(3, 0, 9);
        send_request(make_plain(KIND_CLEAR));
    endtask

    // Size values above the canvas side act as the full side.
    task automatic test_size_clamp();
        set_canvas(300, 2, 255);
        write_register(REG_UNUSED, 511);
        send_request(make_plain(KIND_CLEAR));
        send_request(make_draw(250 * UNIT, 0, 5 * UNIT + UNIT - 1, UNIT, 1'b0, 8'h01));
        send_request(make_read(255, 1));
        set_canvas(511, 1, 255);
        send_request(make_read(200, 0));
    endtask

    // Random phases: each picks a canvas size, clears it, then runs a mix of
    // draws, reads, clears and no-operation requests.
    task automatic test_random_phases(int n_phases);
        int cols;
        int rows;
        for (int p = 0; p < n_phases; p++) begin
            if ($urandom_range(0, 7) == 0) begin
                cols = SIDE;
                rows = $urandom_range(1, 4);
            end else begin
                cols = $urandom_range(1, 20);
                rows = ($urandom_range(0, 7) == 0 && cols <= 8) ? SIDE : $urandom_range(1, 20);
            end
            set_canvas(cols, rows, $urandom_range(0, 255));
            send_request(make_plain(KIND_CLEAR));
            repeat (12)
                send_request(random_request(cols, rows));
        end
    endtask

    // Result checker and receiver-side stall pattern; stalls come in bursts
    // while idling is enabled.
    always @(posedge clk) begin : check_results
        raster_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: cell_value %0d, status %0d",
                       cell_value, status);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (cell_value !== want.cell_value) begin
                    $error("cell_value: expected %0d, got %0d", want.cell_value, cell_value);
                    n_errors++;
                end
                if (status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    n_errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (idling && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    initial begin
        model_cols       = RST_CANVAS_WIDTH;
        model_rows       = RST_CANVAS_HEIGHT;
        model_background = RST_BACKGROUND;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        kind        <= KIND_IDLE;
        rect_x      <= '0;
        rect_y      <= '0;
        rect_w      <= '0;
        rect_h      <= '0;
        fill_mode   <= 1'b0;
        paint       <= '0;
        read_col    <= '0;
        read_row    <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_CANVAS_WIDTH;
        cfg_wr_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_rejected_draws();
        test_full_canvas_draw();
        test_outline_and_extremes();
        test_resize_keeps_cells();
        test_zero_size();
        test_size_clamp();
        test_random_phases(4);
        // The closing phases run back to back with no gaps or stalls.
        settle();
        idling = 1'b0;
        test_random_phases(2);
        settle();
        repeat (10) @(posedge clk);

        $display("Ran %0d requests over %0d canvas settings: %0d draws (%0d refused), %0d reads.",
                 n_requests, n_settings, n_draws, n_rejected, n_reads);
        $display("Covered clears, fills, outlines, size clamping, empty canvases and resizing.");
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial begin
        #10000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
